/* hw/rtl/gmds_pkg.sv */
package gmds_pkg;

    localparam int GRID_ROWS       = 8;
    localparam int GRID_COLS       = 8;
    localparam int COORD_W         = 3;
    localparam int DIR_W           = 2;
    localparam int PROBE_W         = 3;
    localparam int CELL_AW         = 2 * COORD_W;
    localparam int CELL_COUNT      = 1 << CELL_AW;
    localparam int STACK_AW        = 6;
    localparam int STACK_DEPTH     = 1 << STACK_AW;
    localparam int DEPTH_W         = STACK_AW + 1;
    localparam int PROBES_PER_CELL = 4;

    localparam logic [COORD_W:0]   ROW_LIMIT  = (COORD_W + 1)'(GRID_ROWS);
    localparam logic [COORD_W:0]   COL_LIMIT  = (COORD_W + 1)'(GRID_COLS);
    localparam logic [COORD_W-1:0] LAST_COL   = COORD_W'(GRID_COLS - 1);
    localparam logic [PROBE_W-1:0] PROBE_STOP = PROBE_W'(PROBES_PER_CELL);

    // Cell word: bit 0 is open, bit 1 is the visited mark.
    localparam int CELL_OPEN_BIT = 0;
    localparam int CELL_SEEN_BIT = 1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SOLVE = 1'b1
    } op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIR_W-1:0]   dir;
        logic [PROBE_W-1:0] probe;
    } frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_CHK,
        ST_PROBE,
        ST_CHECK,
        ST_RESTORE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic probe;
        logic enter;
        logic pop;
        logic restore;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic can_enter;
        logic cand_exit;
        logic frame_done;
        logic depth_one;
        logic pend_valid;
        logic slot_free;
    } status_t;

endpackage

/* hw/rtl/gmds_req_if.sv */
interface gmds_req_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [gmds_pkg::COORD_W-1:0]    row;
    logic [gmds_pkg::COORD_W-1:0]    col;
    logic                            cell_open;
    logic [gmds_pkg::DIR_W-1:0]      start_dir;

    modport source (
        output valid, operation, row, col, cell_open, start_dir,
        input  ready
    );

    modport sink (
        input  valid, operation, row, col, cell_open, start_dir,
        output ready
    );
endinterface

/* hw/rtl/gmds_res_if.sv */
interface gmds_res_if;
    logic                            valid;
    logic                            ready;
    logic [gmds_pkg::COORD_W-1:0]    out_row;
    logic [gmds_pkg::COORD_W-1:0]    out_col;
    logic                            visited;
    logic                            reached_exit;
    logic                            last;

    modport source (
        output valid, out_row, out_col, visited, reached_exit, last,
        input  ready
    );

    modport sink (
        input  valid, out_row, out_col, visited, reached_exit, last,
        output ready
    );
endinterface

/* hw/rtl/gmds_datapath.sv */
module gmds_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gmds_pkg::cmd_t                cmd,
    output gmds_pkg::status_t             status,
    input  logic [gmds_pkg::COORD_W-1:0]  row,
    input  logic [gmds_pkg::COORD_W-1:0]  col,
    input  logic                          cell_open,
    input  logic [gmds_pkg::DIR_W-1:0]    start_dir,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gmds_pkg::COORD_W-1:0]  out_row,
    output logic [gmds_pkg::COORD_W-1:0]  out_col,
    output logic                          out_visited,
    output logic                          out_reached_exit,
    output logic                          out_last
);
    import gmds_pkg::*;

    logic [1:0]            cell_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] cell_vld_reg;
    logic [1:0]            cell_q_reg;
    logic                  cell_q_vld_reg;

    frame_t                stack_mem [STACK_DEPTH];
    frame_t                stack_q_reg;
    frame_t                top_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    depth_next;

    logic [COORD_W-1:0]    cand_row_reg;
    logic [COORD_W-1:0]    cand_col_reg;
    logic [DIR_W-1:0]      cand_dir_reg;
    logic                  cand_in_reg;

    logic                  pend_valid_reg;
    logic [COORD_W-1:0]    pend_row_reg;
    logic [COORD_W-1:0]    pend_col_reg;
    logic                  pend_exit_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_W-1:0]    out_row_reg;
    logic [COORD_W-1:0]    out_col_reg;
    logic                  out_visited_reg;
    logic                  out_exit_reg;
    logic                  out_last_reg;

    dir_t                  probe_dir;
    logic [COORD_W:0]      nb_row;
    logic [COORD_W:0]      nb_col;
    logic                  nb_in_grid;
    logic                  start_in_grid;

    logic                  rd_en;
    logic [CELL_AW-1:0]    rd_addr;
    logic                  wr_en;
    logic [CELL_AW-1:0]    wr_addr;
    logic [1:0]            wr_data;
    logic                  push_en;
    logic [STACK_AW-1:0]   push_addr;
    logic [STACK_AW-1:0]   pop_addr;
    logic                  out_load;

    // The probe index walks the neighbor order that the frame's direction selects.
    always_comb
    begin
        probe_dir = dir_t'(top_reg.dir + 2'd3 + top_reg.probe[DIR_W-1:0]);
        nb_row    = {1'b0, top_reg.row};
        nb_col    = {1'b0, top_reg.col};
        case (probe_dir)
            DIR_DOWN:  nb_row = {1'b0, top_reg.row} + 1'b1;
            DIR_RIGHT: nb_col = {1'b0, top_reg.col} + 1'b1;
            DIR_UP:    nb_row = {1'b0, top_reg.row} - 1'b1;
            DIR_LEFT:  nb_col = {1'b0, top_reg.col} - 1'b1;
            default:   nb_col = {1'b0, top_reg.col};
        endcase
    end

    // A step off the low edge wraps to all ones and so fails the limit compare.
    assign nb_in_grid    = (nb_row < ROW_LIMIT) && (nb_col < COL_LIMIT);
    assign start_in_grid = ({1'b0, row} < ROW_LIMIT) && ({1'b0, col} < COL_LIMIT);

    assign rd_en   = cmd.start || cmd.probe;
    assign rd_addr = cmd.start ? {row, col} : {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
    assign wr_en   = (cmd.load_wr && start_in_grid) || cmd.enter;
    assign wr_addr = cmd.enter ? {cand_row_reg, cand_col_reg} : {row, col};
    assign wr_data = cmd.enter ? 2'b11 : {1'b0, cell_open};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            cell_q_reg <= cell_mem[rd_addr];
        end
    end

    // Cells never written read as walls through these valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg   <= '0;
            cell_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                cell_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                cell_q_vld_reg <= cell_vld_reg[rd_addr];
            end
        end
    end

    // The top frame lives in registers; the memory holds the frames below it.
    assign push_en   = cmd.enter && (depth_reg != '0);
    assign push_addr = STACK_AW'(depth_reg - 1'b1);
    assign pop_addr  = STACK_AW'(depth_reg - 2'd2);

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[push_addr] <= top_reg;
        end
        if (cmd.pop)
        begin
            stack_q_reg <= stack_mem[pop_addr];
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.start)
        begin
            depth_next = '0;
        end
        else if (cmd.enter)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enter)
        begin
            top_reg <= '{row: cand_row_reg, col: cand_col_reg,
                         dir: cand_dir_reg, probe: '0};
        end
        else if (cmd.probe)
        begin
            top_reg.probe <= top_reg.probe + 1'b1;
        end
        else if (cmd.restore)
        begin
            top_reg <= stack_q_reg;
        end

        if (cmd.start)
        begin
            cand_row_reg <= row;
            cand_col_reg <= col;
            cand_dir_reg <= start_dir;
            cand_in_reg  <= start_in_grid;
        end
        else if (cmd.probe)
        begin
            cand_row_reg <= nb_row[COORD_W-1:0];
            cand_col_reg <= nb_col[COORD_W-1:0];
            cand_dir_reg <= probe_dir;
            cand_in_reg  <= nb_in_grid;
        end

        if (cmd.enter)
        begin
            pend_row_reg  <= cand_row_reg;
            pend_col_reg  <= cand_col_reg;
            pend_exit_reg <= (cand_col_reg == LAST_COL);
        end

        if (out_load)
        begin
            if (cmd.flush && !pend_valid_reg)
            begin
                out_row_reg     <= '0;
                out_col_reg     <= '0;
                out_visited_reg <= 1'b0;
                out_exit_reg    <= 1'b0;
            end
            else
            begin
                out_row_reg     <= pend_row_reg;
                out_col_reg     <= pend_col_reg;
                out_visited_reg <= 1'b1;
                out_exit_reg    <= pend_exit_reg;
            end
            out_last_reg <= cmd.flush;
        end
    end

    // The newest entered cell is held back one step so that its last flag is known.
    assign out_load = (cmd.enter && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start || cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.enter)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    assign status.can_enter  = cand_in_reg && cell_q_vld_reg &&
                               cell_q_reg[CELL_OPEN_BIT] && !cell_q_reg[CELL_SEEN_BIT];
    assign status.cand_exit  = (cand_col_reg == LAST_COL);
    assign status.frame_done = (top_reg.probe >= PROBE_STOP);
    assign status.depth_one  = (depth_reg == DEPTH_W'(1));
    assign status.pend_valid = pend_valid_reg;
    assign status.slot_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_row          = out_row_reg;
    assign out_col          = out_col_reg;
    assign out_visited      = out_visited_reg;
    assign out_reached_exit = out_exit_reg;
    assign out_last         = out_last_reg;

endmodule

/* hw/rtl/gmds_ctrl.sv */
module gmds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_operation,
    output logic              req_ready,
    input  gmds_pkg::status_t status,
    output gmds_pkg::cmd_t    cmd
);
    import gmds_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (op_t'(req_operation) == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_START_CHK;
                    end
                end
            end
            ST_START_CHK:
            begin
                if (status.can_enter)
                begin
                    cmd.enter  = 1'b1;
                    state_next = status.cand_exit ? ST_FLUSH : ST_PROBE;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_PROBE:
            begin
                if (status.frame_done)
                begin
                    cmd.pop    = 1'b1;
                    state_next = status.depth_one ? ST_FLUSH : ST_RESTORE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.can_enter)
                begin
                    state_next = ST_PROBE;
                end
                else if (!status.pend_valid || status.slot_free)
                begin
                    cmd.enter  = 1'b1;
                    state_next = status.cand_exit ? ST_FLUSH : ST_PROBE;
                end
            end
            ST_RESTORE:
            begin
                cmd.restore = 1'b1;
                state_next  = ST_PROBE;
            end
            ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/grid_maze_dfs_solver_core.sv */
// Depth-first maze walker over an 8 x 8 grid. A load request (operation 0) writes one
// cell as open or wall and clears its visited mark; cells outside the grid are ignored.
// A solve request (operation 1) walks from the given cell and direction and returns one
// result per entered cell, in order of entry, with last set on the final one; the walk
// ends after the first cell in the last column or when every branch is exhausted, and a
// solve that enters nothing returns one result with visited 0. Visited marks persist
// across solves. A solve starts with a start cell read, then a check and enter; each
// neighbor probe is a cell memory read, then a check and enter; a backtrack pops the
// stack memory, then restores the parent frame; a close ends the walk. A stalled result
// port holds the walk when the next cell is entered. New requests are taken only between
// solves, while the final result may still wait in the output register.
module grid_maze_dfs_solver_core (
    input  logic       clk,
    input  logic       rst_n,
    gmds_req_if.sink   req,
    gmds_res_if.source res
);
    import gmds_pkg::*;

    cmd_t    cmd;
    status_t status;

    gmds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .status        (status),
        .cmd           (cmd)
    );

    gmds_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .row              (req.row),
        .col              (req.col),
        .cell_open        (req.cell_open),
        .start_dir        (req.start_dir),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .out_row          (res.out_row),
        .out_col          (res.out_col),
        .out_visited      (res.visited),
        .out_reached_exit (res.reached_exit),
        .out_last         (res.last)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import gmds_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               cell_open;
        logic [DIR_W-1:0]   start_dir;
    } walk_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               visited;
        logic               reached_exit;
        logic               last;
    } walk_res_t;

    logic clk;
    logic rst_n;

    gmds_req_if req_bus ();
    gmds_res_if res_bus ();

    grid_maze_dfs_solver_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    // Shadow of the block: cell words, walk stack and the cells each solve enters.
    logic [1:0] cell_map [CELL_COUNT] = '{default: 2'b00};
    frame_t     walk_frames [STACK_DEPTH];
    int         walk_depth = 0;
    bit         exit_hit = 1'b0;
    int         entered_cnt = 0;

    walk_req_t  pending_reqs [$];
    walk_res_t  expected_cells [$];
    walk_req_t  cur_req;
    int         req_total = 0;
    int         mismatch_cnt = 0;
    int         result_cnt = 0;
    int         cycle_count;

    int         gap_left;
    bit         tx_burst;
    int         stall_left;
    bit         rx_burst;

    function automatic void queue_request(op_t op, int r, int c, bit open, int d);
        walk_req_t q;
        q.op        = op;
        q.row       = COORD_W'(r);
        q.col       = COORD_W'(c);
        q.cell_open = open;
        q.start_dir = DIR_W'(d);
        pending_reqs.push_back(q);
        req_total++;
    endfunction

    function automatic void enter_cell(int r, int c, logic [DIR_W-1:0] d);
        int        idx;
        walk_res_t hit;
        frame_t    f;
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS || exit_hit)
            return;
        idx = r * 8 + c;
        if (!cell_map[idx][CELL_OPEN_BIT] || cell_map[idx][CELL_SEEN_BIT])
            return;
        if (entered_cnt >= STACK_DEPTH || walk_depth >= STACK_DEPTH)
            return;
        cell_map[idx][CELL_SEEN_BIT] = 1'b1;
        hit.row          = COORD_W'(r);
        hit.col          = COORD_W'(c);
        hit.visited      = 1'b1;
        hit.reached_exit = (c == GRID_COLS - 1);
        hit.last         = 1'b0;
        expected_cells.push_back(hit);
        entered_cnt++;
        if (c == GRID_COLS - 1)
            exit_hit = 1'b1;
        f.row   = COORD_W'(r);
        f.col   = COORD_W'(c);
        f.dir   = d;
        f.probe = '0;
        walk_frames[walk_depth] = f;
        walk_depth++;
    endfunction

    function automatic void predict_request(walk_req_t q);
        frame_t           f;
        logic [DIR_W-1:0] cd;
        int               nr;
        int               nc;
        walk_res_t        tail;
        if (q.op == OP_LOAD) begin
            if (q.row < GRID_ROWS && q.col < GRID_COLS)
                cell_map[q.row * 8 + q.col] = {1'b0, q.cell_open};
            return;
        end
        exit_hit    = 1'b0;
        walk_depth  = 0;
        entered_cnt = 0;
        enter_cell(q.row, q.col, q.start_dir);
        while (walk_depth > 0 && !exit_hit) begin
            f = walk_frames[walk_depth-1];
            if (f.probe >= PROBE_STOP) begin
                walk_depth--;
            end
            else begin
                walk_frames[walk_depth-1].probe = f.probe + 1'b1;
                // The neighbor order rotates with the frame direction.
                cd = f.dir + 2'd3 + f.probe[DIR_W-1:0];
                nr = f.row;
                nc = f.col;
                case (dir_t'(cd))
                    DIR_DOWN:  nr = nr + 1;
                    DIR_RIGHT: nc = nc + 1;
                    DIR_UP:    nr = nr - 1;
                    default:   nc = nc - 1;
                endcase
                enter_cell(nr, nc, cd);
            end
        end
        walk_depth = 0;
        if (entered_cnt == 0) begin
            tail = '0;
            tail.last = 1'b1;
            expected_cells.push_back(tail);
        end
        else begin
            tail = expected_cells.pop_back();
            tail.last = 1'b1;
            expected_cells.push_back(tail);
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request driver: the gap after each request is drawn when it is put on the bus.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_bus.valid     <= 1'b0;
            req_bus.operation <= OP_LOAD;
            req_bus.row       <= '0;
            req_bus.col       <= '0;
            req_bus.cell_open <= 1'b0;
            req_bus.start_dir <= '0;
            gap_left          <= 0;
            tx_burst          <= 1'b0;
        end
        else begin
            if (req_bus.valid && req_bus.ready)
                predict_request(cur_req);
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left > 0) begin
                    req_bus.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.operation <= cur_req.op;
                    req_bus.row       <= cur_req.row;
                    req_bus.col       <= cur_req.col;
                    req_bus.cell_open <= cur_req.cell_open;
                    req_bus.start_dir <= cur_req.start_dir;
                    gap_left <= tx_burst ? 0 : $urandom_range(0, 14);
                    if ($urandom_range(0, 39) == 0)
                        tx_burst <= !tx_burst;
                end
                else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own random back-pressure.
    always @(posedge clk or negedge rst_n) begin
        walk_res_t got;
        walk_res_t want;
        int        stall;
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left    <= 0;
            rx_burst      <= 1'b0;
        end
        else if (res_bus.valid && res_bus.ready) begin
            got.row          = res_bus.out_row;
            got.col          = res_bus.out_col;
            got.visited      = res_bus.visited;
            got.reached_exit = res_bus.reached_exit;
            got.last         = res_bus.last;
            result_cnt++;
            if (expected_cells.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result %0d not expected: row %0d col %0d visited %b exit %b last %b",
                             result_cnt, got.row, got.col, got.visited, got.reached_exit,
                             got.last);
            end
            else begin
                want = expected_cells.pop_front();
                if (got.row != want.row || got.col != want.col ||
                    got.visited != want.visited || got.reached_exit != want.reached_exit ||
                    got.last != want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result %0d: expected row %0d col %0d visited %b exit %b ",
                                  "last %b, got row %0d col %0d visited %b exit %b last %b"},
                                 result_cnt, want.row, want.col, want.visited,
                                 want.reached_exit, want.last, got.row, got.col,
                                 got.visited, got.reached_exit, got.last);
                end
            end
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            res_bus.ready <= (stall == 0);
            stall_left    <= stall;
            if ($urandom_range(0, 39) == 0)
                rx_burst <= !rx_burst;
        end
        else if (stall_left > 0) begin
            res_bus.ready <= (stall_left == 1);
            stall_left    <= stall_left - 1;
        end
        else begin
            res_bus.ready <= 1'b1;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int sr;
        int sc;
        int r;
        int c;
        int mode;
        int loads;
        int last_r;
        int last_c;
        bit open;

        rst_n             = 1'b0;
        last_r            = 0;
        last_c            = 0;

        // Solve on an all-wall grid enters nothing.
        queue_request(OP_SOLVE, 0, 0, 1'b1, 0);
        // A small branch that reaches the last column.
        queue_request(OP_LOAD, 2, 5, 1'b1, 3);
        queue_request(OP_LOAD, 2, 6, 1'b1, 0);
        queue_request(OP_LOAD, 1, 6, 1'b1, 1);
        queue_request(OP_LOAD, 3, 6, 1'b1, 2);
        queue_request(OP_LOAD, 2, 7, 1'b1, 0);
        queue_request(OP_SOLVE, 2, 5, 1'b0, 2);
        // The start cell is still marked visited.
        queue_request(OP_SOLVE, 2, 5, 1'b1, 1);
        // A reload clears the mark, but every neighbor is still visited or walled.
        queue_request(OP_LOAD, 2, 5, 1'b1, 0);
        queue_request(OP_SOLVE, 2, 5, 1'b0, 0);
        // Start in the last column.
        queue_request(OP_LOAD, 7, 7, 1'b1, 3);
        queue_request(OP_SOLVE, 7, 7, 1'b0, 3);
        // Corner walk, a reload of the corner, then reloads to walls, one from open to wall.
        queue_request(OP_LOAD, 0, 0, 1'b1, 0);
        queue_request(OP_LOAD, 0, 1, 1'b1, 0);
        queue_request(OP_LOAD, 1, 0, 1'b1, 0);
        queue_request(OP_SOLVE, 0, 0, 1'b0, 1);
        queue_request(OP_LOAD, 0, 0, 1'b1, 2);
        queue_request(OP_SOLVE, 0, 0, 1'b1, 3);
        queue_request(OP_LOAD, 1, 0, 1'b0, 1);
        queue_request(OP_LOAD, 7, 0, 1'b0, 2);
        queue_request(OP_SOLVE, 7, 0, 1'b0, 2);

        while (req_total < RANDOM_ITEMS + 21) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                // Whole new maze, then a walk from an open cell in the first column and one random walk.
                sr = $urandom_range(0, GRID_ROWS - 1);
                for (r = 0; r < GRID_ROWS; r++)
                    for (c = 0; c < GRID_COLS; c++) begin
                        open = (r == sr && c == 0) ? 1'b1 : ($urandom_range(0, 99) < 62);
                        queue_request(OP_LOAD, r, c, open, $urandom_range(0, 3));
                    end
                queue_request(OP_SOLVE, sr, 0, 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3));
                queue_request(OP_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7),
                              1'($urandom_range(0, 1)), $urandom_range(0, 3));
            end
            else if (mode <= 7) begin
                loads = $urandom_range(3, 12);
                repeat (loads) begin
                    r    = $urandom_range(0, 7);
                    c    = $urandom_range(0, 7);
                    open = ($urandom_range(0, 3) != 0);
                    queue_request(OP_LOAD, r, c, open, $urandom_range(0, 3));
                    if (open) begin
                        last_r = r;
                        last_c = c;
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        sr = last_r;
                        sc = last_c;
                    end
                    else begin
                        sr = $urandom_range(0, 7);
                        sc = $urandom_range(0, 7);
                    end
                    queue_request(OP_SOLVE, sr, sc, 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 3));
                end
            end
            else begin
                queue_request(op_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                              $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_cells.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/gmds_pkg.sv
hw/rtl/gmds_req_if.sv
hw/rtl/gmds_res_if.sv
hw/rtl/gmds_datapath.sv
hw/rtl/gmds_ctrl.sv
hw/rtl/grid_maze_dfs_solver_core.sv
tb/sv/tb.sv
